### sv/phr_pkg.sv
// phr_pkg: shared widths, constants and word types for the pixel hue rotate unit.
// No dependencies; every other file of the block imports it.
package phr_pkg;

  localparam int PIX_W      = 8;
  localparam int FRAC_W     = 16;
  // hue numerator and 6*d both stay below 6*255+1
  localparam int HUE_W      = PIX_W + 3;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = FRAC_W / DIV_STAGES;

  localparam logic [FRAC_W:0]   FRAC_ONE    = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [FRAC_W-1:0] SHIFT_RESET = {1'b1, {(FRAC_W-1){1'b0}}};

  // one pixel, red in the lowest bits
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } phr_pix_t;

  // word carried through the two dividers
  typedef struct packed {
    logic [PIX_W-1:0]  mx;       // value, also saturation divisor
    logic              gray;     // max == min: hue and saturation are zero
    logic              s_full;   // min == 0 on a lit pixel: saturation is one
    logic [PIX_W-1:0]  sat_rem;
    logic [FRAC_W-1:0] sat_q;
    logic [HUE_W-1:0]  hue_den;  // 6 * (max - min)
    logic [HUE_W-1:0]  hue_rem;
    logic [FRAC_W-1:0] hue_q;
  } phr_div_t;

endpackage

### sv/pixel_hue_rotate_unit.sv
// pixel_hue_rotate_unit: top level, RGB to HSV, hue rotation, HSV back to RGB.
// Depends on phr_pkg, phr_front, phr_div_pipe (phr_div_lane) and phr_back.
//
//  channel  | handshake            | data
//  ---------+----------------------+-----------------------------------
//  s_       | s_tvalid / s_tready  | s_tdata: red, green, blue
//  m_       | m_tvalid / m_tready  | m_tdata: red, green, blue
//  cfg_     | cfg_valid / cfg_ready| cfg_data: hue shift, 65536 = 1 turn
//
// One word per cycle while m_tready is high, through one front stage,
// four divider stages (four quotient bits each) and three back stages.
// Every stage has its own valid bit and a ready chain, so a stall holds
// each word in place and bubbles close up.
// Reset clears all valid bits and sets the hue shift to half a turn.
// cfg_ready is always high.
module pixel_hue_rotate_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // [15:0] hue_shift
);
  import phr_pkg::*;

  logic [FRAC_W-1:0] hue_shift;
  logic              front_valid, front_ready;
  phr_div_t          front_data;
  logic              div_valid, div_ready;
  phr_div_t          div_data;
  phr_pix_t          out_pix;

  // hue shift register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hue_shift <= cfg_data;
    end
  end

  phr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pix    (phr_pix_t'(s_tdata)),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  phr_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  phr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hue_shift (hue_shift),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (out_pix)
  );

  assign m_tdata = out_pix;

endmodule

### sv/phr_front.sv
// phr_front: first pipeline stage, max/min, chroma and hue numerator of one pixel.
// Depends on phr_pkg.
module phr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phr_pkg::phr_pix_t in_pix,
  output logic              out_valid,
  input  logic              out_ready,
  output phr_pkg::phr_div_t out_data
);
  import phr_pkg::*;

  logic [PIX_W-1:0] r, g, b;
  logic [PIX_W-1:0] mx, mn, d;
  logic [HUE_W-1:0] d_w, two_d, four_d, six_d, n;
  logic             gray, s_full;
  phr_div_t         word_next;

  assign r = in_pix.red;
  assign g = in_pix.green;
  assign b = in_pix.blue;

  // value and chroma
  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  assign d      = mx - mn;
  assign gray   = (d == '0);
  assign s_full = (d == mx) && !gray;
  assign d_w    = {3'b000, d};
  assign two_d  = {d_w[HUE_W-2:0], 1'b0};
  assign four_d = {d_w[HUE_W-3:0], 2'b00};
  assign six_d  = four_d + two_d;

  // hue in sixths times d; ties pick red, then green
  always_comb begin
    priority if (mx == r) begin
      if (g >= b) n = {3'b000, g - b};
      else        n = six_d - {3'b000, b - g};
    end else if (mx == g) begin
      n = two_d + {3'b000, b} - {3'b000, r};
    end else begin
      n = four_d + {3'b000, r} - {3'b000, g};
    end
  end

  // divider start values; zero where a flag overrides the quotient
  always_comb begin
    word_next.mx      = mx;
    word_next.gray    = gray;
    word_next.s_full  = s_full;
    word_next.sat_rem = s_full ? '0 : d;
    word_next.sat_q   = '0;
    word_next.hue_den = six_d;
    word_next.hue_rem = gray ? '0 : n;
    word_next.hue_q   = '0;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= word_next;
    end
  end

endmodule

### sv/phr_div_lane.sv
// phr_div_lane: a few restoring division steps on a remainder that stays below the divisor.
// Depends on phr_pkg for the quotient width and steps per stage.
module phr_div_lane #(
  parameter int DEN_W = 8
) (
  input  logic [DEN_W-1:0]          rem_in,
  input  logic [DEN_W-1:0]          den,
  input  logic [phr_pkg::FRAC_W-1:0] quo_in,
  output logic [DEN_W-1:0]          rem_out,
  output logic [phr_pkg::FRAC_W-1:0] quo_out
);
  import phr_pkg::*;

  logic [DEN_W:0]    trial;
  logic [DEN_W-1:0]  rem;
  logic [FRAC_W-1:0] quo;

  // one quotient bit per step, shifting in zeros
  always_comb begin
    rem   = rem_in;
    quo   = quo_in;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem, 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        quo   = {quo[FRAC_W-2:0], 1'b1};
      end else begin
        quo   = {quo[FRAC_W-2:0], 1'b0};
      end
      rem = trial[DEN_W-1:0];
    end
  end

  assign rem_out = rem;
  assign quo_out = quo;

endmodule

### sv/phr_div_pipe.sv
// phr_div_pipe: pipelined saturation and hue dividers, a few quotient bits per stage.
// Depends on phr_pkg and phr_div_lane.
module phr_div_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phr_pkg::phr_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output phr_pkg::phr_div_t out_data
);
  import phr_pkg::*;

  phr_div_t              stg [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   rdy;

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];
  assign out_valid       = vld[DIV_STAGES-1];
  assign out_data        = stg[DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    phr_div_t          src;
    phr_div_t          word_next;
    logic              src_v;
    phr_div_t          word_q;
    logic              valid_q;
    logic [PIX_W-1:0]  sat_rem;
    logic [FRAC_W-1:0] sat_q;
    logic [HUE_W-1:0]  hue_rem;
    logic [FRAC_W-1:0] hue_q;

    if (k == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_inner
      assign src   = stg[k-1];
      assign src_v = vld[k-1];
    end

    phr_div_lane #(.DEN_W(PIX_W)) u_sat (
      .rem_in  (src.sat_rem),
      .den     (src.mx),
      .quo_in  (src.sat_q),
      .rem_out (sat_rem),
      .quo_out (sat_q)
    );

    phr_div_lane #(.DEN_W(HUE_W)) u_hue (
      .rem_in  (src.hue_rem),
      .den     (src.hue_den),
      .quo_in  (src.hue_q),
      .rem_out (hue_rem),
      .quo_out (hue_q)
    );

    always_comb begin
      word_next         = src;
      word_next.sat_rem = sat_rem;
      word_next.sat_q   = sat_q;
      word_next.hue_rem = hue_rem;
      word_next.hue_q   = hue_q;
    end

    assign rdy[k] = !valid_q || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q <= 1'b0;
      end else if (rdy[k]) begin
        valid_q <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        word_q <= word_next;
      end
    end

    assign stg[k] = word_q;
    assign vld[k] = valid_q;
  end

endmodule

### sv/phr_back.sv
// phr_back: hue rotation, sector split, p/q/t products and output register (three stages).
// Depends on phr_pkg.
module phr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [phr_pkg::FRAC_W-1:0] hue_shift,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  phr_pkg::phr_div_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output phr_pkg::phr_pix_t         out_pix
);
  import phr_pkg::*;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // stage A: saturation, rotated hue, sector and fraction
  logic [FRAC_W:0]   s_eff;
  logic [FRAC_W-1:0] h16, h;
  logic [FRAC_W+2:0] x;
  logic              vld_a, rdy_a;
  logic [PIX_W-1:0]  mx_a;
  logic [FRAC_W:0]   s_a;
  sector_t           sec_a;
  logic [FRAC_W-1:0] f_a;

  // stage B: first products
  logic [2*FRAC_W:0]     fs_prod;
  logic [2*FRAC_W+1:0]   ft_prod;
  logic [PIX_W+FRAC_W:0] p_prod;
  logic                  vld_b, rdy_b;
  logic [PIX_W-1:0]      mx_b, p_b;
  sector_t               sec_b;
  logic [FRAC_W-1:0]     fs_b;
  logic [FRAC_W:0]       ft_b;

  // stage C: q and t, channel select
  logic [PIX_W+FRAC_W:0] q_prod, t_prod;
  logic [PIX_W-1:0]      q_c, t_c;
  phr_pix_t              pix_next;
  logic                  rdy_c;

  assign rdy_c    = !out_valid || out_ready;
  assign rdy_b    = !vld_b || rdy_c;
  assign rdy_a    = !vld_a || rdy_b;
  assign in_ready = rdy_a;

  // stage A logic
  always_comb begin
    priority if (in_data.gray)   s_eff = '0;
    else if (in_data.s_full)     s_eff = FRAC_ONE;
    else                         s_eff = {1'b0, in_data.sat_q};
  end

  assign h16 = in_data.gray ? '0 : in_data.hue_q;
  assign h   = h16 + hue_shift;
  assign x   = {1'b0, h, 2'b00} + {2'b00, h, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (rdy_a) begin
      vld_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      mx_a  <= in_data.mx;
      s_a   <= s_eff;
      sec_a <= sector_t'(x[FRAC_W+2:FRAC_W]);
      f_a   <= x[FRAC_W-1:0];
    end
  end

  // stage B logic
  assign fs_prod = f_a * s_a;
  assign ft_prod = (FRAC_ONE - {1'b0, f_a}) * s_a;
  assign p_prod  = mx_a * (FRAC_ONE - s_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (rdy_b) begin
      vld_b <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && vld_a) begin
      mx_b  <= mx_a;
      sec_b <= sec_a;
      fs_b  <= fs_prod[2*FRAC_W-1:FRAC_W];
      ft_b  <= ft_prod[2*FRAC_W:FRAC_W];
      p_b   <= p_prod[PIX_W+FRAC_W-1:FRAC_W];
    end
  end

  // stage C logic
  assign q_prod = mx_b * (FRAC_ONE - {1'b0, fs_b});
  assign t_prod = mx_b * (FRAC_ONE - ft_b);
  assign q_c    = q_prod[PIX_W+FRAC_W-1:FRAC_W];
  assign t_c    = t_prod[PIX_W+FRAC_W-1:FRAC_W];

  always_comb begin
    unique case (sec_b)
      SEC_RED_YEL: begin
        pix_next.red = mx_b; pix_next.green = t_c;  pix_next.blue = p_b;
      end
      SEC_YEL_GRN: begin
        pix_next.red = q_c;  pix_next.green = mx_b; pix_next.blue = p_b;
      end
      SEC_GRN_CYN: begin
        pix_next.red = p_b;  pix_next.green = mx_b; pix_next.blue = t_c;
      end
      SEC_CYN_BLU: begin
        pix_next.red = p_b;  pix_next.green = q_c;  pix_next.blue = mx_b;
      end
      SEC_BLU_MAG: begin
        pix_next.red = t_c;  pix_next.green = p_b;  pix_next.blue = mx_b;
      end
      default: begin
        pix_next.red = mx_b; pix_next.green = p_b;  pix_next.blue = q_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_c) begin
      out_valid <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vld_b) begin
      out_pix <= pix_next;
    end
  end

`ifndef SYNTHESIS
  // the darkest component never exceeds the value
  a_p_below_value: assert property (@(posedge clk) disable iff (rst)
    vld_b |-> (p_b <= mx_b))
    else $error("p above value");

  // the complement product is at most one full fraction
  a_ft_bound: assert property (@(posedge clk) disable iff (rst)
    vld_b |-> (ft_b <= FRAC_ONE))
    else $error("t fraction out of range");

  // a word taken into the output register shows up there next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (vld_b && rdy_c) |=> out_valid)
    else $error("word lost at output register");
`endif

endmodule
